FILE: rtl/mffd_pkg.sv
`default_nettype none
package mffd_pkg;

	// block defaults
	localparam int MOTOR_COUNT_DEF     = 4;
	localparam int COUNTS_PER_TURN_DEF = 8192;
	localparam int HALF_TURN_DEF       = 4096;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// field widths
	localparam int IDENT_W    = 11;
	localparam int LENGTH_W   = 4;
	localparam int WORD_W     = 16;
	localparam int INDEX_W    = 2;
	localparam int ASCALE_W   = 24;
	localparam int VSCALE_W   = 17;
	localparam int CSCALE_W   = 17;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;

	// accepted frame length
	localparam logic [LENGTH_W-1:0] FRAME_LENGTH_OK = 4'd8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_IDENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT    = 2'd3;

	// register reset values
	localparam logic [IDENT_W-1:0]  BASE_IDENT_RST = 11'd513;
	localparam logic [ASCALE_W-1:0] ANGLE_RST      = 24'd383930;
	localparam logic [VSCALE_W-1:0] VELOCITY_RST   = 17'd3413;
	localparam logic [CSCALE_W-1:0] CURRENT_RST    = 17'd80000;

	// one classified frame waiting for the arithmetic
	typedef struct packed {
		logic [INDEX_W-1:0]       motor_index;
		logic signed [WORD_W-1:0] turn;
		logic signed [WORD_W-1:0] position;
		logic signed [WORD_W-1:0] speed;
		logic signed [WORD_W-1:0] current;
	} entry_t;

	// scale registers seen by the back end
	typedef struct packed {
		logic [ASCALE_W-1:0] angle;
		logic [VSCALE_W-1:0] velocity;
		logic [CSCALE_W-1:0] current;
	} scale_cfg_t;

endpackage
`default_nettype wire

FILE: rtl/mffd_front.sv
`default_nettype none
module mffd_front #(
	parameter int MOTOR_COUNT = mffd_pkg::MOTOR_COUNT_DEF,
	parameter int HALF_TURN   = mffd_pkg::HALF_TURN_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [mffd_pkg::IDENT_W-1:0]         frame_identifier,
	input  wire logic [mffd_pkg::LENGTH_W-1:0]        frame_length,
	input  wire logic signed [mffd_pkg::WORD_W-1:0]   position_word,
	input  wire logic signed [mffd_pkg::WORD_W-1:0]   speed_word,
	input  wire logic signed [mffd_pkg::WORD_W-1:0]   current_word,
	input  wire logic [mffd_pkg::IDENT_W-1:0]         base_identifier,
	output logic                                      push_valid,
	input  wire logic                                 push_ready,
	output mffd_pkg::entry_t                          push_data
);

	localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam int DIFF_W = mffd_pkg::WORD_W + 1;
	localparam logic signed [DIFF_W-1:0] HALF_POS = DIFF_W'(HALF_TURN);
	localparam logic signed [DIFF_W-1:0] HALF_NEG = -DIFF_W'(HALF_TURN);

	logic signed [mffd_pkg::WORD_W-1:0] prev_pos_q [MOTOR_COUNT];
	logic signed [mffd_pkg::WORD_W-1:0] turn_q     [MOTOR_COUNT];

	logic [mffd_pkg::IDENT_W:0]         offset;
	logic                               frame_ok;
	logic                               in_fire;
	logic [MIDX_W-1:0]                  midx;
	logic signed [DIFF_W-1:0]           step;
	logic signed [mffd_pkg::WORD_W-1:0] turn_cur;
	logic signed [mffd_pkg::WORD_W-1:0] turn_next;

	// queue space decides acceptance; rejected frames are simply dropped
	assign in_ready = push_ready;
	assign in_fire  = in_valid && push_ready;

	// identifier window and length check
	always_comb begin
		offset   = {1'b0, frame_identifier} - {1'b0, base_identifier};
		frame_ok = (frame_length == mffd_pkg::FRAME_LENGTH_OK) && !offset[mffd_pkg::IDENT_W]
			&& (offset[mffd_pkg::IDENT_W-1:0] < mffd_pkg::IDENT_W'(MOTOR_COUNT));
		midx     = offset[MIDX_W-1:0];
	end

	// encoder step and turn count update
	always_comb begin
		turn_cur  = turn_q[midx];
		step      = DIFF_W'(position_word) - DIFF_W'(prev_pos_q[midx]);
		turn_next = turn_cur;
		if (step > HALF_POS) begin
			turn_next = turn_cur - 16'sd1;
		end else if (step < HALF_NEG) begin
			turn_next = turn_cur + 16'sd1;
		end
	end

	// per-motor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				prev_pos_q[i] <= '0;
				turn_q[i]     <= '0;
			end
		end else if (in_fire && frame_ok) begin
			prev_pos_q[midx] <= position_word;
			turn_q[midx]     <= turn_next;
		end
	end

	// classified transaction toward the queue
	always_comb begin
		push_valid            = in_fire && frame_ok;
		push_data.motor_index = offset[mffd_pkg::INDEX_W-1:0];
		push_data.turn        = turn_next;
		push_data.position    = position_word;
		push_data.speed       = speed_word;
		push_data.current     = current_word;
	end

endmodule
`default_nettype wire

FILE: rtl/mffd_queue.sv
`default_nettype none
module mffd_queue (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push_valid,
	output logic            push_ready,
	input  wire mffd_pkg::entry_t push_data,
	output logic            pop_valid,
	input  wire logic       pop_ready,
	output mffd_pkg::entry_t pop_data
);

	localparam int DEPTH  = mffd_pkg::QUEUE_DEPTH;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	mffd_pkg::entry_t  slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mffd_back.sv
`default_nettype none
module mffd_back #(
	parameter int COUNTS_PER_TURN = mffd_pkg::COUNTS_PER_TURN_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                pop_valid,
	output logic                                     pop_ready,
	input  wire mffd_pkg::entry_t                    pop_data,
	input  wire mffd_pkg::scale_cfg_t                scale,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [mffd_pkg::INDEX_W-1:0]             motor_index,
	output logic signed [mffd_pkg::WORD_W-1:0]       angle_tenths,
	output logic signed [mffd_pkg::WORD_W-1:0]       shaft_speed,
	output logic signed [mffd_pkg::WORD_W-1:0]       current_milliamps
);

	localparam int W     = mffd_pkg::WORD_W;
	localparam int CPT_W = $clog2(COUNTS_PER_TURN + 1) + 1;
	localparam int TOT_W = W + CPT_W + 1;
	localparam int AS_W  = mffd_pkg::ASCALE_W;
	localparam int AP_W  = TOT_W + AS_W + 1;
	localparam int AQ_W  = AP_W - AS_W;
	localparam int FR_W  = 16;
	localparam int SP_W  = W + mffd_pkg::VSCALE_W + 1;
	localparam int SQ_W  = SP_W - FR_W;
	localparam int CP_W  = W + mffd_pkg::CSCALE_W + 1;
	localparam int CQ_W  = CP_W - FR_W;
	localparam logic signed [TOT_W-1:0] CPT_X = TOT_W'(COUNTS_PER_TURN);

	logic advance;

	logic                           v_s1;
	logic [mffd_pkg::INDEX_W-1:0]   idx_s1;
	logic signed [TOT_W-1:0]        total_s1;
	logic signed [SP_W-1:0]         spd_prod_s1;
	logic signed [CP_W-1:0]         cur_prod_s1;

	logic                           v_s2;
	logic [mffd_pkg::INDEX_W-1:0]   idx_s2;
	logic signed [AP_W-1:0]         ang_prod_s2;
	logic signed [W-1:0]            speed_s2;
	logic signed [W-1:0]            milli_s2;

	logic                           v_s3;
	logic [mffd_pkg::INDEX_W-1:0]   idx_s3;
	logic signed [W-1:0]            angle_s3;
	logic signed [W-1:0]            speed_s3;
	logic signed [W-1:0]            milli_s3;

	logic signed [SP_W-1:0]         spd_bias;
	logic signed [SQ_W-1:0]         spd_q;
	logic signed [CP_W-1:0]         cur_bias;
	logic signed [CQ_W-1:0]         cur_q;
	logic signed [AP_W-1:0]         ang_bias;
	logic signed [AQ_W-1:0]         ang_q;
	logic signed [W-1:0]            speed_sat;
	logic signed [W-1:0]            milli_sat;
	logic signed [W-1:0]            angle_sat;

	localparam logic signed [SQ_W-1:0] SP_MAX = SQ_W'(32767);
	localparam logic signed [CQ_W-1:0] CP_MAX = CQ_W'(32767);
	localparam logic signed [AQ_W-1:0] AQ_MAX = AQ_W'(32767);

	// whole pipeline moves unless the output transaction is stalled
	assign advance   = !v_s3 || out_ready;
	assign pop_ready = advance;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= pop_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: multi-turn count total and rate products
	always_ff @(posedge clk) begin
		if (advance) begin
			idx_s1      <= pop_data.motor_index;
			total_s1    <= TOT_W'(pop_data.turn) * CPT_X + TOT_W'(pop_data.position);
			spd_prod_s1 <= SP_W'(pop_data.speed) * $signed(SP_W'(scale.velocity));
			cur_prod_s1 <= CP_W'(pop_data.current) * $signed(CP_W'(scale.current));
		end
	end

	// speed and current: round toward zero, then saturate
	always_comb begin
		spd_bias = spd_prod_s1 + (spd_prod_s1[SP_W-1] ? SP_W'((1 << FR_W) - 1) : SP_W'(0));
		spd_q    = spd_bias[SP_W-1:FR_W];
		if (spd_q > SP_MAX) begin
			speed_sat = 16'sh7fff;
		end else if (spd_q < ~SP_MAX) begin
			speed_sat = -16'sh8000;
		end else begin
			speed_sat = spd_q[W-1:0];
		end
		cur_bias = cur_prod_s1 + (cur_prod_s1[CP_W-1] ? CP_W'((1 << FR_W) - 1) : CP_W'(0));
		cur_q    = cur_bias[CP_W-1:FR_W];
		if (cur_q > CP_MAX) begin
			milli_sat = 16'sh7fff;
		end else if (cur_q < ~CP_MAX) begin
			milli_sat = -16'sh8000;
		end else begin
			milli_sat = cur_q[W-1:0];
		end
	end

	// stage 2: angle product
	always_ff @(posedge clk) begin
		if (advance) begin
			idx_s2      <= idx_s1;
			ang_prod_s2 <= AP_W'(total_s1) * $signed(AP_W'(scale.angle));
			speed_s2    <= speed_sat;
			milli_s2    <= milli_sat;
		end
	end

	// angle: round toward zero, then saturate
	always_comb begin
		ang_bias = ang_prod_s2 + (ang_prod_s2[AP_W-1] ? AP_W'((1 << AS_W) - 1) : AP_W'(0));
		ang_q    = ang_bias[AP_W-1:AS_W];
		if (ang_q > AQ_MAX) begin
			angle_sat = 16'sh7fff;
		end else if (ang_q < ~AQ_MAX) begin
			angle_sat = -16'sh8000;
		end else begin
			angle_sat = ang_q[W-1:0];
		end
	end

	// stage 3: output register
	always_ff @(posedge clk) begin
		if (advance) begin
			idx_s3   <= idx_s2;
			angle_s3 <= angle_sat;
			speed_s3 <= speed_s2;
			milli_s3 <= milli_s2;
		end
	end

	assign out_valid         = v_s3;
	assign motor_index       = idx_s3;
	assign angle_tenths      = angle_s3;
	assign shaft_speed       = speed_s3;
	assign current_milliamps = milli_s3;

endmodule
`default_nettype wire

FILE: rtl/motor_feedback_frame_decoder_top.sv
// Motor feedback frame decoder. Each accepted bus frame of length 8 whose
// identifier lies in base_identifier .. base_identifier + MOTOR_COUNT - 1 updates
// that motor's multi-turn encoder unwrap and yields one result: motor index,
// output-shaft angle in 0.1 degree, shaft speed in rpm and current in mA, each
// scaled by its fixed-point register, truncated toward zero and saturated to
// 16 bits; other frames are accepted and dropped. The block takes one frame per
// clock cycle while the queue has room; results pass the two-entry queue and the
// three-stage multiply pipeline of the back end. The user must write the scale
// registers through cfg_we / cfg_index / cfg_data only while idle; not enforced.
`default_nettype none
module motor_feedback_frame_decoder_top #(
	parameter int MOTOR_COUNT     = mffd_pkg::MOTOR_COUNT_DEF,
	parameter int COUNTS_PER_TURN = mffd_pkg::COUNTS_PER_TURN_DEF,
	parameter int HALF_TURN       = mffd_pkg::HALF_TURN_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [mffd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [mffd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [mffd_pkg::IDENT_W-1:0]        frame_identifier,
	input  wire logic [mffd_pkg::LENGTH_W-1:0]       frame_length,
	input  wire logic signed [mffd_pkg::WORD_W-1:0]  position_word,
	input  wire logic signed [mffd_pkg::WORD_W-1:0]  speed_word,
	input  wire logic signed [mffd_pkg::WORD_W-1:0]  current_word,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [mffd_pkg::INDEX_W-1:0]             motor_index,
	output logic signed [mffd_pkg::WORD_W-1:0]       angle_tenths,
	output logic signed [mffd_pkg::WORD_W-1:0]       shaft_speed,
	output logic signed [mffd_pkg::WORD_W-1:0]       current_milliamps
);

	logic [mffd_pkg::IDENT_W-1:0] base_q;
	mffd_pkg::scale_cfg_t         scale_q;

	logic              push_valid;
	logic              push_ready;
	mffd_pkg::entry_t  push_data;
	logic              pop_valid;
	logic              pop_ready;
	mffd_pkg::entry_t  pop_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q           <= mffd_pkg::BASE_IDENT_RST;
			scale_q.angle    <= mffd_pkg::ANGLE_RST;
			scale_q.velocity <= mffd_pkg::VELOCITY_RST;
			scale_q.current  <= mffd_pkg::CURRENT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mffd_pkg::REG_BASE_IDENT: base_q           <= cfg_data[mffd_pkg::IDENT_W-1:0];
				mffd_pkg::REG_ANGLE:      scale_q.angle    <= cfg_data[mffd_pkg::ASCALE_W-1:0];
				mffd_pkg::REG_VELOCITY:   scale_q.velocity <= cfg_data[mffd_pkg::VSCALE_W-1:0];
				mffd_pkg::REG_CURRENT:    scale_q.current  <= cfg_data[mffd_pkg::CSCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// front: classify and unwrap
	mffd_front #(
		.MOTOR_COUNT (MOTOR_COUNT),
		.HALF_TURN   (HALF_TURN)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.frame_identifier (frame_identifier),
		.frame_length     (frame_length),
		.position_word    (position_word),
		.speed_word       (speed_word),
		.current_word     (current_word),
		.base_identifier  (base_q),
		.push_valid       (push_valid),
		.push_ready       (push_ready),
		.push_data        (push_data)
	);

	// queue between front and back
	mffd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back: scaling pipeline
	mffd_back #(
		.COUNTS_PER_TURN (COUNTS_PER_TURN)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.pop_valid         (pop_valid),
		.pop_ready         (pop_ready),
		.pop_data          (pop_data),
		.scale             (scale_q),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.motor_index       (motor_index),
		.angle_tenths      (angle_tenths),
		.shaft_speed       (shaft_speed),
		.current_milliamps (current_milliamps)
	);

	// a frame of the wrong length never reaches the queue
	a_bad_length_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (frame_length != mffd_pkg::FRAME_LENGTH_OK)) |-> !push_valid)
		else $error("frame of wrong length pushed");

	// an identifier below the window never reaches the queue
	a_low_ident_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (frame_identifier < base_q)) |-> !push_valid)
		else $error("identifier below window pushed");

	// the back end takes nothing while its output is stalled
	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !(pop_valid && pop_ready))
		else $error("queue popped while output stalled");

endmodule
`default_nettype wire
